// ----- rtl/arp_binding_change_detector_top_assert.svh -----
// Assertion macros used by the ARP binding change detector top level.
// Each macro expects i_clk and i_rst_n in scope of the including module.
`ifndef ARP_BINDING_CHANGE_DETECTOR_TOP_ASSERT_SVH
`define ARP_BINDING_CHANGE_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARPBCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARPBCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/arpbcd_pkg.sv -----
// Package for the ARP binding change detector: field widths, status codes,
// table entry and compare result types. No dependencies.
`default_nettype none

package arpbcd_pkg;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int STAMP_W  = 32;
    localparam int WINDOW_W = 16;
    localparam int STATUS_W = 3;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd40;

    localparam logic [STATUS_W-1:0] ST_REFRESHED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REPLACED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CHANGE_ALERT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL_RESET   = 3'd4;

    typedef struct packed {
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic hit;
        logic same_mac;
        logic young;
    } t_match;

    function automatic logic status_alert(input logic [STATUS_W-1:0] status);
        return (status == ST_CHANGE_ALERT) || (status == ST_FULL_RESET);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/arpbcd_in_if.sv -----
// Sighting channel: valid/ready plus IP, MAC and timestamp.
// Depends on arpbcd_pkg for field widths.
`default_nettype none

interface arpbcd_in_if;
    import arpbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [IP_W-1:0]    ip_addr;
    logic [MAC_W-1:0]   mac_addr;
    logic [STAMP_W-1:0] now_seconds;

    modport source (output valid, output ip_addr, output mac_addr, output now_seconds,
                    input ready);
    modport sink   (input valid, input ip_addr, input mac_addr, input now_seconds,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/arpbcd_out_if.sv -----
// Result channel: valid/ready plus alert flag and status code.
// Depends on arpbcd_pkg for field widths.
`default_nettype none

interface arpbcd_out_if;
    import arpbcd_pkg::*;

    logic                valid;
    logic                ready;
    logic                alert;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output alert, output status, input ready);
    modport sink   (input valid, input alert, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/arpbcd_cfg_if.sv -----
// Configuration write channel: valid/ready plus alert window data.
// Depends on arpbcd_pkg for the data width.
`default_nettype none

interface arpbcd_cfg_if;
    import arpbcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/arp_binding_change_detector_top.sv -----
// Top level of the ARP binding change detector: sequencer, config register,
// result register. Depends on arpbcd_pkg, the three channel interfaces,
// arpbcd_store, arpbcd_match and the assertion macro header.
//
//   Channel   Dir   Modport  Payload
//   i_in      in    sink     ip_addr[31:0], mac_addr[47:0], now_seconds[31:0]
//   o_out     out   source   alert, status[2:0]
//   i_cfg     in    sink     data[15:0] (alert_window)
//
// One sighting scans the table one slot per cycle through the single memory
//   read port, with a registered read and a registered compare behind it.
// A hit stops the scan early; a miss scans all valid slots.
// Reset clears the entry count, the window (to 40) and all handshake state;
//   table contents are left as they are, only slots below the count are read.
// i_in is taken only when the block is idle; a result waiting on o_out does
//   not block the next sighting until that one's own result is ready.
`default_nettype none
`include "arp_binding_change_detector_top_assert.svh"

module arp_binding_change_detector_top #(
    parameter int ENTRIES = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    arpbcd_in_if.sink    i_in,
    arpbcd_out_if.source o_out,
    arpbcd_cfg_if.sink   i_cfg
);
    import arpbcd_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    // Control state
    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_v1, n_v1;
    logic [AW-1:0]       r_idx1;
    logic [WINDOW_W-1:0] r_window;
    logic                r_out_valid, n_out_valid;

    // Decision held between scan end and commit
    logic [STATUS_W-1:0] r_dec_status, n_dec_status;
    logic                r_dec_we, n_dec_we;
    logic [AW-1:0]       r_dec_addr, n_dec_addr;

    // Sighting under work and result register
    logic [IP_W-1:0]     r_ip;
    logic [MAC_W-1:0]    r_mac;
    logic [STAMP_W-1:0]  r_now;
    logic                r_alert;
    logic [STATUS_W-1:0] r_status;

    t_entry              rd_entry;
    t_entry              wr_entry;
    t_match              m;
    logic [AW-1:0]       m_idx;
    logic                in_fire;
    logic                issue;
    logic                commit;
    logic                table_full;

    assign in_fire    = i_in.valid && i_in.ready;
    assign issue      = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign commit     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    assign table_full = (r_count == CW'(ENTRIES));
    assign wr_entry   = '{ip: r_ip, mac: r_mac, stamp: r_now};

    arpbcd_store #(
        .DEPTH (ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (commit && r_dec_we),
        .i_wr_addr (r_dec_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_entry)
    );

    // Stale compares that land after the scan ends are ignored outside S_SCAN.
    arpbcd_match #(
        .AW (AW)
    ) u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v1 && (r_state == S_SCAN)),
        .i_idx    (r_idx1),
        .i_entry  (rd_entry),
        .i_ip     (r_ip),
        .i_mac    (r_mac),
        .i_now    (r_now),
        .i_window (r_window),
        .o_match  (m),
        .o_idx    (m_idx)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_v1         = 1'b0;
        n_out_valid  = r_out_valid;
        n_dec_status = r_dec_status;
        n_dec_we     = r_dec_we;
        n_dec_addr   = r_dec_addr;

        // Drop the result once taken.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_rd_idx = '0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (m.valid && m.hit) begin
                    // First matching slot wins.
                    n_state    = S_DONE;
                    n_dec_addr = m_idx;
                    if (m.same_mac) begin
                        n_dec_status = ST_REFRESHED;
                        n_dec_we     = 1'b1;
                    end else if (m.young) begin
                        n_dec_status = ST_CHANGE_ALERT;
                        n_dec_we     = 1'b0;
                    end else begin
                        n_dec_status = ST_REPLACED;
                        n_dec_we     = 1'b1;
                    end
                end else if (!issue && !r_v1 && !m.valid) begin
                    // Scan drained with no hit: append or flush.
                    n_state    = S_DONE;
                    n_dec_addr = r_count[AW-1:0];
                    if (table_full) begin
                        n_dec_status = ST_FULL_RESET;
                        n_dec_we     = 1'b0;
                    end else begin
                        n_dec_status = ST_INSERTED;
                        n_dec_we     = 1'b1;
                    end
                end else begin
                    n_v1 = issue;
                    if (issue) begin
                        n_rd_idx = r_rd_idx + CW'(1);
                    end
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_dec_status == ST_INSERTED) begin
                        n_count = r_count + CW'(1);
                    end else if (r_dec_status == ST_FULL_RESET) begin
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_rd_idx     <= '0;
            r_v1         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_window     <= WINDOW_RESET;
            r_dec_status <= ST_REFRESHED;
            r_dec_we     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_rd_idx     <= n_rd_idx;
            r_v1         <= n_v1;
            r_out_valid  <= n_out_valid;
            r_dec_status <= n_dec_status;
            r_dec_we     <= n_dec_we;
            if (i_cfg.valid && i_cfg.ready) begin
                r_window <= i_cfg.data;
            end
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge i_clk) begin
        r_idx1     <= r_rd_idx[AW-1:0];
        r_dec_addr <= n_dec_addr;
        if (in_fire) begin
            r_ip  <= i_in.ip_addr;
            r_mac <= i_in.mac_addr;
            r_now <= i_in.now_seconds;
        end
        if (commit) begin
            r_status <= r_dec_status;
            r_alert  <= status_alert(r_dec_status);
        end
    end

    // Hold both input channels off while reset is asserted.
    assign i_in.ready   = (r_state == S_IDLE) && i_rst_n;
    assign i_cfg.ready  = i_rst_n;
    assign o_out.valid  = r_out_valid;
    assign o_out.alert  = r_alert;
    assign o_out.status = r_status;

    `ARPBCD_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(ENTRIES), "entry count above table size")
    `ARPBCD_ASSERT_NOW(a_scan_bound, r_state == S_SCAN, r_rd_idx <= r_count, "scan index past entry count")
    `ARPBCD_ASSERT_NEXT(a_insert_count, commit && (r_dec_status == ST_INSERTED), r_count == $past(r_count) + CW'(1), "insert did not advance count")
    `ARPBCD_ASSERT_NEXT(a_full_clear, commit && (r_dec_status == ST_FULL_RESET), r_count == '0, "table full did not clear count")

endmodule

`default_nettype wire

// ----- rtl/arpbcd_store.sv -----
// Binding table memory: one write port, one registered read port.
// Depends on arpbcd_pkg for the entry type.
`default_nettype none

module arpbcd_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_wr_addr,
    input  wire arpbcd_pkg::t_entry i_wr_data,
    input  wire [AW-1:0]         i_rd_addr,
    output arpbcd_pkg::t_entry   o_rd_data
);
    import arpbcd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/arpbcd_match.sv -----
// Shared compare unit: checks one stored entry against the sighting per cycle
// and registers IP hit, MAC equality and the 33-bit window test.
// Depends on arpbcd_pkg for entry and result types.
`default_nettype none

module arpbcd_match #(
    parameter int AW = 10
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    input  wire [AW-1:0]                      i_idx,
    input  wire arpbcd_pkg::t_entry           i_entry,
    input  wire [arpbcd_pkg::IP_W-1:0]        i_ip,
    input  wire [arpbcd_pkg::MAC_W-1:0]       i_mac,
    input  wire [arpbcd_pkg::STAMP_W-1:0]     i_now,
    input  wire [arpbcd_pkg::WINDOW_W-1:0]    i_window,
    output arpbcd_pkg::t_match                o_match,
    output logic [AW-1:0]                     o_idx
);
    import arpbcd_pkg::*;

    localparam int SUM_W = STAMP_W + 1;

    logic             r_valid;
    logic             r_hit;
    logic             r_same_mac;
    logic             r_young;
    logic [AW-1:0]    r_idx;
    logic [SUM_W-1:0] deadline;

    // Unwrapped stamp + window, compared against now.
    assign deadline = {1'b0, i_entry.stamp} + {{(SUM_W-WINDOW_W){1'b0}}, i_window};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit      <= (i_entry.ip == i_ip);
        r_same_mac <= (i_entry.mac == i_mac);
        r_young    <= (deadline > {1'b0, i_now});
        r_idx      <= i_idx;
    end

    assign o_match.valid    = r_valid;
    assign o_match.hit      = r_hit;
    assign o_match.same_mac = r_same_mac;
    assign o_match.young    = r_young;
    assign o_idx            = r_idx;

endmodule

`default_nettype wire

// ----- test/arp_binding_change_detector_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for arp_binding_change_detector_top: drives sightings and window writes,
// checks every alert/status result against a binding-table predictor.
// Depends on arpbcd_pkg, the three channel interfaces and the top level RTL.

module arp_binding_change_detector_top_test;
    import arpbcd_pkg::*;

    // Table size of the block as delivered.
    localparam int TB_ENTRIES  = 1024;
    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 5;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_HOLD   = 400;
    localparam int IP_POOL     = 24;
    localparam int PHASE_ITEMS = 112;
    localparam int MAX_REPORTS = 10;
    localparam int FILL_RUN    = 14;

    typedef struct packed {
        logic                alert;
        logic [STATUS_W-1:0] status;
    } t_result;

    // Receiver ready patterns; each lasts a random number of cycles.
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} t_sink_mode;

    // Binding table mirror plus the queue of results still owed by the block.
    class binding_scoreboard;
        logic [IP_W-1:0]     ip_tab[TB_ENTRIES];
        logic [MAC_W-1:0]    mac_tab[TB_ENTRIES];
        logic [STAMP_W-1:0]  stamp_tab[TB_ENTRIES];
        int unsigned         count;
        logic [WINDOW_W-1:0] window;
        t_result             owed_q[$];
        int                  mismatches;
        int                  results_seen;
        int                  status_hits[8];

        function new();
            count        = 0;
            window       = WINDOW_RESET;
            mismatches   = 0;
            results_seen = 0;
            foreach (status_hits[k]) status_hits[k] = 0;
        endfunction

        function void set_window(input logic [WINDOW_W-1:0] value);
            window = value;
        endfunction

        function logic [STATUS_W-1:0] update_binding(input logic [IP_W-1:0] ip,
                                                     input logic [MAC_W-1:0] mac,
                                                     input logic [STAMP_W-1:0] now);
            logic [STAMP_W:0] deadline;
            for (int i = 0; i < count; i++) begin
                if (ip_tab[i] == ip) begin
                    if (mac_tab[i] == mac) begin
                        stamp_tab[i] = now;
                        return ST_REFRESHED;
                    end
                    deadline = {1'b0, stamp_tab[i]} + {{(STAMP_W+1-WINDOW_W){1'b0}}, window};
                    if (deadline > {1'b0, now})
                        return ST_CHANGE_ALERT;
                    mac_tab[i]   = mac;
                    stamp_tab[i] = now;
                    return ST_REPLACED;
                end
            end
            if (count < TB_ENTRIES) begin
                ip_tab[count]    = ip;
                mac_tab[count]   = mac;
                stamp_tab[count] = now;
                count++;
                return ST_INSERTED;
            end
            count = 0;
            return ST_FULL_RESET;
        endfunction

        function void note_sighting(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                    input logic [STAMP_W-1:0] now);
            t_result owed;
            owed.status = update_binding(ip, mac, now);
            owed.alert  = (owed.status == ST_CHANGE_ALERT) || (owed.status == ST_FULL_RESET);
            status_hits[owed.status]++;
            owed_q.push_back(owed);
        endfunction

        function void check_result(input logic alert, input logic [STATUS_W-1:0] status);
            t_result owed;
            results_seen++;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result alert=%0b status=%0d", $realtime,
                             alert, status);
                return;
            end
            owed = owed_q.pop_front();
            if (alert !== owed.alert || status !== owed.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result mismatch: expected alert=%0b status=%0d, got alert=%0b status=%0d",
                             $realtime, owed.alert, owed.status, alert, status);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    arpbcd_in_if  in_ch ();
    arpbcd_out_if out_ch ();
    arpbcd_cfg_if cfg_ch ();

    arp_binding_change_detector_top #(
        .ENTRIES(TB_ENTRIES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    binding_scoreboard sb;
    int cycle_count   = 0;
    int hold_requests = 0;
    int sightings_sent = 0;
    int window_writes = 0;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Watchdog: give up once the run is far past its slowest correct length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still owed", cycle_count,
                     sb.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // Check each result transaction at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.alert, out_ch.status);
    end

    // Result receiver: switch between ready patterns, and on request hold ready low
    // for a long stretch so the block backs up into its input.
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         hold_left;
        int         holds_served;
        mode         = SINK_OPEN;
        mode_left    = 0;
        hold_left    = 0;
        holds_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_OPEN:   out_ch.ready <= 1'b1;
                    SINK_COIN:   out_ch.ready <= ($urandom_range(0, 1) == 1);
                    SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 4) == 0);
                    default:     out_ch.ready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[MAC_W-1:0];
    endfunction

    // Offer one sighting and hold it until accepted. Leave valid high so a
    // following call continues the burst without a bubble.
    task automatic send_sighting(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac,
                                 input logic [STAMP_W-1:0] now);
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.ip_addr     <= ip;
        in_ch.mac_addr    <= mac;
        in_ch.now_seconds <= now;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_sighting(ip, mac, now);
        sightings_sent++;
    endtask

    // Drop valid and stay idle for the given number of cycles (zero: keep going).
    task automatic idle_gap(input int cycles);
        if (cycles == 0)
            return;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Quiesce: stop offering, collect every owed result, then let the block settle.
    task automatic drain_block();
        idle_gap(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WINDOW_W-1:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_window(value);
        window_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Directed sightings under the reset window of 40 seconds.
    task automatic directed_sightings();
        // Insert, refresh, then a MAC change one second inside the window.
        send_sighting(32'h0000_0000, 48'h0000_0000_0000, 32'd0);
        send_sighting(32'h0000_0000, 48'h0000_0000_0000, 32'd5);
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'd44);
        idle_gap(2);
        // Exactly at the window edge the MAC is replaced.
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'd45);
        // All-ones fields; stamp plus window must not wrap at 32 bits.
        send_sighting(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFF0);
        send_sighting(32'hFFFF_FFFF, 48'h0000_0000_0000, 32'hFFFF_FFFF);
        idle_gap(1);
        // Time going backwards: refresh to an older stamp, then an alert.
        send_sighting(32'h0000_0000, 48'h0000_0000_0001, 32'd10);
        send_sighting(32'h0000_0000, 48'h0000_0000_0002, 32'd3);
        // Append a run of new IPs with short gaps, then revisit slot 0 late.
        for (int k = 0; k < FILL_RUN; k++) begin
            send_sighting(32'hC0A8_0100 + k, random_mac(), 32'd1000 + k);
            if (k % 5 == 4)
                idle_gap(k % 3);
        end
        send_sighting(32'h0000_FFFF, 48'h5A5A_A5A5_5A5A, 32'd2000);
        send_sighting(32'h0000_0000, 48'hA5A5_5A5A_A5A5, 32'd2001);
    endtask

    // Random sightings from a small IP pool, so hits, MAC changes and window
    // edges recur, with stray random IPs that keep the table growing. Time
    // mostly creeps forward at a pace tied to the window, with occasional
    // backward steps and jumps.
    task automatic random_phase(input int items, input bit with_pressure);
        logic [IP_W-1:0]    pool_ip[IP_POOL];
        logic [MAC_W-1:0]   pool_mac_a[IP_POOL];
        logic [MAC_W-1:0]   pool_mac_b[IP_POOL];
        logic [STAMP_W-1:0] clock_now;
        logic [IP_W-1:0]    ip;
        logic [MAC_W-1:0]   mac;
        int                 left;
        int                 burst;
        int                 pick;
        int                 roll;
        int unsigned        win;
        for (int k = 0; k < IP_POOL; k++) begin
            pool_ip[k]    = $urandom;
            pool_mac_a[k] = random_mac();
            pool_mac_b[k] = random_mac();
        end
        clock_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 : $urandom;
        win  = sb.window;
        left = items;
        if (with_pressure)
            hold_requests++;
        while (left > 0) begin
            burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 8);
            for (int j = 0; j < burst && left > 0; j++) begin
                pick = $urandom_range(0, IP_POOL - 1);
                ip   = ($urandom_range(0, 9) == 0) ? $urandom : pool_ip[pick];
                roll = $urandom_range(0, 19);
                if (roll < 9)
                    mac = pool_mac_a[pick];
                else if (roll < 18)
                    mac = pool_mac_b[pick];
                else
                    mac = random_mac();
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    clock_now = $urandom;
                else if (roll < 10)
                    clock_now = clock_now - $urandom_range(0, win + 1);
                else
                    clock_now = clock_now + $urandom_range(0, win / 12 + 1);
                send_sighting(ip, mac, clock_now);
                left--;
            end
            idle_gap($urandom_range(0, 6));
        end
    endtask

    // Main sequence: reset, directed checks, then random phases under several windows.
    initial begin : stimulus
        logic [WINDOW_W-1:0] windows[5];
        windows[0] = 16'd0;
        windows[1] = 16'hFFFF;
        windows[2] = WINDOW_W'($urandom_range(2, 16'hFFFE));
        windows[3] = 16'd1;
        windows[4] = WINDOW_RESET;

        sb = new();
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.ip_addr     = '0;
        in_ch.mac_addr    = '0;
        in_ch.now_seconds = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.data       = '0;

        // Hold reset asserted, then release it once.
        repeat (RESET_LEN) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_sightings();

        for (int p = 0; p < 5; p++) begin
            drain_block();
            write_window(windows[p]);
            // With a zero window a MAC change at the same second is replaced.
            if (p == 0) begin
                send_sighting(32'h8000_0001, 48'h0000_0000_00AA, 32'd5000);
                send_sighting(32'h8000_0001, 48'h0000_0000_00BB, 32'd5000);
            end
            random_phase(PHASE_ITEMS, p == 1);
        end

        // Collect the tail and watch for stray results.
        idle_gap(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TB_ENTRIES + 20) @(posedge i_clk);

        $display("Covered %0d sightings and %0d window writes (0, 1, 40, 65535, mid-range); %0d results checked.",
                 sightings_sent, window_writes, sb.results_seen);
        $display("Refreshed %0d, inserted %0d, replaced %0d, change alerts %0d, table-full resets %0d.",
                 sb.status_hits[ST_REFRESHED], sb.status_hits[ST_INSERTED],
                 sb.status_hits[ST_REPLACED], sb.status_hits[ST_CHANGE_ALERT],
                 sb.status_hits[ST_FULL_RESET]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results never arrived", sb.mismatches, sb.pending());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/arpbcd_pkg.sv
rtl/arpbcd_in_if.sv
rtl/arpbcd_out_if.sv
rtl/arpbcd_cfg_if.sv
rtl/arpbcd_store.sv
rtl/arpbcd_match.sv
rtl/arp_binding_change_detector_top.sv
test/arp_binding_change_detector_top_test.sv
